[sv/csc_pkg.sv]
// Shared types, constants and tables for the CORDIC sine/cosine block.
package csc_pkg;

   localparam int MAX_ITERATIONS = 32;
   localparam int FRACTION_BITS  = 30;
   localparam int COUNT_W        = 6;
   localparam int STEP_W         = 5;
   localparam int ANGLE_W        = 40;   // internal angle, 32 fraction bits
   localparam int VEC_W          = 34;   // x and y, FRACTION_BITS fraction bits

   localparam logic signed [ANGLE_W-1:0] PI_Q32      = 40'sd13493037705;
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q32 = 40'sd6746518852;
   localparam logic signed [ANGLE_W-1:0] TWO_PI_Q32  = 40'sd26986075409;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD,
      ST_ROTATE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_END,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_FOLD,
      OP_ROTATE,
      OP_MUL_X,
      OP_MUL_Y,
      OP_MUL_END
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [STEP_W-1:0] step;
      logic [STEP_W-1:0] gain_index;
   } dp_ctrl_type;

   // atan(2^-j) at 32 fraction bits; a plain power of two from j = 11 on
   function automatic logic [32:0] step_angle(input logic [STEP_W-1:0] j);
      logic [32:0] a;
      a = '0;
      unique case (j)
         5'd0:  a = 33'd3373259426;
         5'd1:  a = 33'd1991351318;
         5'd2:  a = 33'd1052175346;
         5'd3:  a = 33'd534100635;
         5'd4:  a = 33'd268086748;
         5'd5:  a = 33'd134174063;
         5'd6:  a = 33'd67103403;
         5'd7:  a = 33'd33553749;
         5'd8:  a = 33'd16777131;
         5'd9:  a = 33'd8388597;
         5'd10: a = 33'd4194303;
         default: a = 33'd1 << (6'd32 - {1'b0, j});
      endcase
      return a;
   endfunction

   // cumulative gain after (index + 1) rotations, 32 fraction bits
   function automatic logic [31:0] gain_q32(input logic [STEP_W-1:0] index);
      logic [31:0] g;
      g = 32'd2608131496;
      unique case (index)
         5'd0:  g = 32'd3037000500;
         5'd1:  g = 32'd2716375826;
         5'd2:  g = 32'd2635271635;
         5'd3:  g = 32'd2614921743;
         5'd4:  g = 32'd2609829388;
         5'd5:  g = 32'd2608555990;
         5'd6:  g = 32'd2608237621;
         5'd7:  g = 32'd2608158028;
         5'd8:  g = 32'd2608138129;
         5'd9:  g = 32'd2608133154;
         5'd10: g = 32'd2608131911;
         5'd11: g = 32'd2608131600;
         5'd12: g = 32'd2608131522;
         5'd13: g = 32'd2608131503;
         5'd14: g = 32'd2608131498;
         5'd15: g = 32'd2608131497;
         default: g = 32'd2608131496;
      endcase
      return g;
   endfunction

endpackage

[sv/csc_datapath.sv]
// Angle reduction, shared shift-add rotation unit and gain multiplier.
module csc_datapath import csc_pkg::*; (
   input  logic                     clock,
   input  dp_ctrl_type              ctrl,
   input  logic signed [31:0]       angle,
   output logic signed [31:0]       cosine,
   output logic signed [31:0]       sine
);

   logic signed [ANGLE_W-1:0] theta_ff, theta_in;
   logic signed [VEC_W-1:0]   x_ff, x_in;
   logic signed [VEC_W-1:0]   y_ff, y_in;
   logic                      flip_ff, flip_in;
   logic [63:0]               mul_ff, mul_in;

   logic signed [ANGLE_W-1:0] theta_raw;
   logic signed [VEC_W-1:0]   dx, dy;
   logic signed [ANGLE_W-1:0] step_ang;
   logic [31:0]               gain;
   logic [VEC_W-1:0]          mag_x, mag_y;

   function automatic logic [VEC_W-1:0] magnitude(input logic signed [VEC_W-1:0] v);
      return v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
   endfunction

   // sign restored to the rounded product hi*g + round(lo*g / 2^32)
   function automatic logic signed [VEC_W-1:0] rescale(input logic signed [VEC_W-1:0] v,
                                                       input logic [VEC_W-1:0] m,
                                                       input logic [63:0] p,
                                                       input logic [31:0] g);
      logic [34:0] r;
      logic [63:0] rounded;
      rounded = p + 64'h0000_0000_8000_0000;
      r = (m[32] ? 35'(g) : 35'd0) + (m[33] ? 35'({g, 1'b0}) : 35'd0)
          + 35'(rounded[63:32]);
      return v[VEC_W-1] ? -VEC_W'(r) : VEC_W'(r);
   endfunction

   function automatic logic signed [31:0] finish(input logic signed [VEC_W-1:0] v,
                                                input logic flip);
      logic [VEC_W-1:0] m;
      logic [31:0]      c;
      m = magnitude(v);
      c = (m > VEC_W'(1 << FRACTION_BITS)) ? 32'(1 << FRACTION_BITS) : m[31:0];
      return (v[VEC_W-1] ^ flip) ? -c : c;
   endfunction

   assign theta_raw = {{(ANGLE_W-36){angle[31]}}, angle, 4'b0000};
   assign dx        = y_ff >>> ctrl.step;
   assign dy        = x_ff >>> ctrl.step;
   assign step_ang  = signed'(ANGLE_W'(step_angle(ctrl.step)));
   assign gain      = gain_q32(ctrl.gain_index);
   assign mag_x     = magnitude(x_ff);
   assign mag_y     = magnitude(y_ff);

   always_comb begin
      theta_in = theta_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      flip_in  = flip_ff;
      mul_in   = mul_ff;
      unique case (ctrl.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            // single 2pi correction into [-pi, pi)
            priority if (theta_raw >= PI_Q32) begin
               theta_in = theta_raw - TWO_PI_Q32;
            end else if (theta_raw < -PI_Q32) begin
               theta_in = theta_raw + TWO_PI_Q32;
            end else begin
               theta_in = theta_raw;
            end
            x_in    = VEC_W'(1 << FRACTION_BITS);
            y_in    = '0;
            flip_in = 1'b0;
         end
         OP_FOLD: begin
            priority if (theta_ff < -HALF_PI_Q32) begin
               theta_in = theta_ff + PI_Q32;
               flip_in  = 1'b1;
            end else if (theta_ff > HALF_PI_Q32) begin
               theta_in = theta_ff - PI_Q32;
               flip_in  = 1'b1;
            end
         end
         OP_ROTATE: begin
            if (theta_ff[ANGLE_W-1]) begin
               x_in     = x_ff + dx;
               y_in     = y_ff - dy;
               theta_in = theta_ff + step_ang;
            end else begin
               x_in     = x_ff - dx;
               y_in     = y_ff + dy;
               theta_in = theta_ff - step_ang;
            end
         end
         OP_MUL_X: begin
            mul_in = 64'(mag_x[31:0]) * 64'(gain);
         end
         OP_MUL_Y: begin
            x_in   = rescale(x_ff, mag_x, mul_ff, gain);
            mul_in = 64'(mag_y[31:0]) * 64'(gain);
         end
         OP_MUL_END: begin
            y_in = rescale(y_ff, mag_y, mul_ff, gain);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      theta_ff <= theta_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      flip_ff  <= flip_in;
      mul_ff   <= mul_in;
   end

   assign cosine = finish(x_ff, flip_ff);
   assign sine   = finish(y_ff, flip_ff);

endmodule

[sv/cordic_sine_cosine_top.sv]
// Top level: sequencer, configuration register and result register.
//
// Cosine and sine of a radian angle by rotation-mode CORDIC.
// req_angle is two's complement with 28 fraction bits; rsp_cosine and
// rsp_sine carry 30 fraction bits and are saturated to +-1.
// All channels are valid/ready. csr_iteration_count sets the number of
// rotations N (values above 32 act as 32, zero gives (+-1, 0) unscaled);
// csr_ready is high outside reset, writes belong only to idle periods.
// One transaction is in work at a time: after acceptance the sequencer
// folds the angle, makes N rotations in the shared shift-add rotation
// unit, passes x and y through the gain multiplier (shared by x and y)
// in states MUL_X, MUL_Y and MUL_END, and loads the result register in
// its finishing state, going there straight from the fold for N = 0.
// req_ready is high only while idle.
// The result sits in an output register; if the receiver stalls, the
// finished transaction waits there and a following one may still be taken
// and worked on until its own result needs the register.
// Synchronous reset returns the sequencer to idle, drops rsp_valid and
// sets the count to 32; both ready outputs are low while reset is high.
module cordic_sine_cosine_top import csc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [COUNT_W-1:0]  csr_iteration_count,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_angle,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_cosine,
   output logic signed [31:0]  rsp_sine
);

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [COUNT_W-1:0] step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] cosine_ff, sine_ff;
   logic               load_result;
   dp_ctrl_type        ctrl;
   logic signed [31:0] dp_cosine, dp_sine;
   logic [COUNT_W-1:0] step_next;

   assign csr_ready = ~reset;
   assign count_in  = (csr_valid && csr_ready) ? csr_iteration_count : count_ff;
   assign step_next = step_ff + COUNT_W'(1);

   always_comb begin
      state_in        = state_ff;
      n_in            = n_ff;
      step_in         = step_ff;
      load_result     = 1'b0;
      req_ready       = 1'b0;
      ctrl.op         = OP_NONE;
      ctrl.step       = step_ff[STEP_W-1:0];
      ctrl.gain_index = STEP_W'(n_ff - COUNT_W'(1));
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = ~reset;
            if (req_valid && req_ready) begin
               ctrl.op  = OP_LOAD;
               n_in     = (count_ff > COUNT_W'(MAX_ITERATIONS)) ?
                          COUNT_W'(MAX_ITERATIONS) : count_ff;
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            ctrl.op  = OP_FOLD;
            step_in  = '0;
            state_in = (n_ff == '0) ? ST_FINISH : ST_ROTATE;
         end
         ST_ROTATE: begin
            ctrl.op = OP_ROTATE;
            step_in = step_next;
            if (step_next == n_ff) begin
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            ctrl.op  = OP_MUL_X;
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            ctrl.op  = OP_MUL_Y;
            state_in = ST_MUL_END;
         end
         ST_MUL_END: begin
            ctrl.op  = OP_MUL_END;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_result = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_W'(MAX_ITERATIONS);
         n_ff         <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         n_ff         <= n_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_result) begin
         cosine_ff <= dp_cosine;
         sine_ff   <= dp_sine;
      end
   end

   csc_datapath u_datapath (
      .clock  (clock),
      .ctrl   (ctrl),
      .angle  (req_angle),
      .cosine (dp_cosine),
      .sine   (dp_sine)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_cosine = cosine_ff;
   assign rsp_sine   = sine_ff;

endmodule

[bench/tb_top.sv]
// Self-checking bench for the CORDIC sine/cosine block: driver, monitor and predictor.
`timescale 1ns / 1ps

module tb_top import csc_pkg::*; ();

   localparam longint ANGLE_PI      = 64'sd13493037705;
   localparam longint ANGLE_HALF_PI = 64'sd6746518852;
   localparam longint ANGLE_TWO_PI  = 64'sd26986075409;
   localparam longint UNIT_ONE      = 64'sd1073741824;
   // input codes just past pi and pi/2 (28 fraction bits)
   localparam logic signed [31:0] CODE_PI      = 32'sd843314857;
   localparam logic signed [31:0] CODE_HALF_PI = 32'sd421657429;
   localparam int PHASE_ITEMS  = 155;
   localparam int DRAIN_EVERY  = 97;
   localparam int SETTLE       = 50;
   localparam int STALL_LIMIT  = 4000;

   typedef struct {
      logic signed [31:0] cosine;
      logic signed [31:0] sine;
      logic signed [31:0] angle;
      logic [COUNT_W-1:0] count;
   } sincos_type;

   typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_CHOKE} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [COUNT_W-1:0] csr_iteration_count = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_cosine;
   logic signed [31:0] rsp_sine;

   logic signed [31:0] angle_queue[$];
   sincos_type pending_sincos[$];
   sincos_type want;
   logic [COUNT_W-1:0] count_setting = 6'd32;
   int pushed_count = 0;
   int sent_count = 0;
   int rsp_count = 0;
   int error_count = 0;
   int idle_cycles = 0;
   int burst_left;
   int gap_left;
   bit drain_hold;
   rx_mode_type rx_mode;
   int mode_left;

   cordic_sine_cosine_top DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_iteration_count (csr_iteration_count),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_angle           (req_angle),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cosine          (rsp_cosine),
      .rsp_sine            (rsp_sine)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // atan(2^-j), 32 fraction bits
   function automatic longint atan_step(input int j);
      case (j)
         0:  return 64'sd3373259426;
         1:  return 64'sd1991351318;
         2:  return 64'sd1052175346;
         3:  return 64'sd534100635;
         4:  return 64'sd268086748;
         5:  return 64'sd134174063;
         6:  return 64'sd67103403;
         7:  return 64'sd33553749;
         8:  return 64'sd16777131;
         9:  return 64'sd8388597;
         10: return 64'sd4194303;
         default: return 64'sd1 <<< (32 - j);
      endcase
   endfunction

   // cumulative gain after the given number of rotations (1 and up)
   function automatic bit [31:0] cum_gain(input int rotations);
      case (rotations)
         1:  return 32'd3037000500;
         2:  return 32'd2716375826;
         3:  return 32'd2635271635;
         4:  return 32'd2614921743;
         5:  return 32'd2609829388;
         6:  return 32'd2608555990;
         7:  return 32'd2608237621;
         8:  return 32'd2608158028;
         9:  return 32'd2608138129;
         10: return 32'd2608133154;
         11: return 32'd2608131911;
         12: return 32'd2608131600;
         13: return 32'd2608131522;
         14: return 32'd2608131503;
         15: return 32'd2608131498;
         16: return 32'd2608131497;
         default: return 32'd2608131496;
      endcase
   endfunction

   // magnitude times gain, rounded to nearest with halves away from zero
   function automatic longint apply_gain(input longint v, input bit [31:0] g);
      bit [63:0] mag;
      bit [63:0] hi;
      bit [63:0] lo;
      bit [63:0] prod;
      bit neg;
      neg = v < 0;
      mag = neg ? -v : v;
      hi = mag >> 32;
      lo = mag & 64'hFFFF_FFFF;
      prod = hi * g + ((lo * g + 64'h8000_0000) >> 32);
      return neg ? -$signed(prod) : $signed(prod);
   endfunction

   function automatic longint clamp_unit(input longint v);
      if (v > UNIT_ONE) return UNIT_ONE;
      if (v < -UNIT_ONE) return -UNIT_ONE;
      return v;
   endfunction

   function automatic sincos_type predict_sincos(input logic signed [31:0] angle,
                                                 input logic [COUNT_W-1:0] count);
      longint theta;
      longint x;
      longint y;
      longint dx;
      longint dy;
      int rotations;
      bit flip;
      sincos_type r;
      theta = longint'(angle) * 64'sd16;
      flip = 1'b0;
      if (theta >= ANGLE_PI) theta -= ANGLE_TWO_PI;
      else if (theta < -ANGLE_PI) theta += ANGLE_TWO_PI;
      if (theta < -ANGLE_HALF_PI) begin
         theta += ANGLE_PI;
         flip = 1'b1;
      end else if (theta > ANGLE_HALF_PI) begin
         theta -= ANGLE_PI;
         flip = 1'b1;
      end
      rotations = (count > MAX_ITERATIONS) ? MAX_ITERATIONS : int'(count);
      x = UNIT_ONE;
      y = 0;
      for (int j = 0; j < rotations; j++) begin
         dx = y >>> j;
         dy = x >>> j;
         if (theta < 0) begin
            x += dx;
            y -= dy;
            theta += atan_step(j);
         end else begin
            x -= dx;
            y += dy;
            theta -= atan_step(j);
         end
      end
      if (rotations > 0) begin
         x = apply_gain(x, cum_gain(rotations));
         y = apply_gain(y, cum_gain(rotations));
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      x = clamp_unit(x);
      y = clamp_unit(y);
      r.cosine = x[31:0];
      r.sine = y[31:0];
      r.angle = angle;
      r.count = count;
      return r;
   endfunction

   function automatic logic signed [31:0] random_angle();
      logic signed [31:0] edge_code;
      case ($urandom_range(0, 3))
         0, 1: return $urandom;
         2: return $urandom_range(0, 2 * (CODE_PI - 1)) - (CODE_PI - 1);
         default: begin
            case ($urandom_range(0, 6))
               0: edge_code = 32'sd0;
               1: edge_code = CODE_HALF_PI;
               2: edge_code = -CODE_HALF_PI;
               3: edge_code = CODE_PI;
               4: edge_code = -CODE_PI;
               5: edge_code = 32'sh7FFF_FFFF;
               default: edge_code = 32'sh8000_0000;
            endcase
            return edge_code + $urandom_range(0, 64) - 32;
         end
      endcase
   endfunction

   task automatic push_angle(input logic signed [31:0] angle);
      angle_queue.push_back(angle);
      pushed_count++;
   endtask

   task automatic wait_drained();
      while (rsp_count < pushed_count) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_iteration_count <= value;
      do @(posedge clock); while (!csr_ready);
      count_setting = value;
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [COUNT_W-1:0] count);
      write_count(count);
      repeat (PHASE_ITEMS) push_angle(random_angle());
      wait_drained();
   endtask

   // sender: bursts of random length, random gaps, and an occasional full drain
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = $urandom_range(1, 16);
         gap_left = 0;
         drain_hold = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            sent_count++;
            if (sent_count % DRAIN_EVERY == 0) drain_hold = 1'b1;
         end
         if (drain_hold && rsp_count >= sent_count) drain_hold = 1'b0;
         if (req_valid && !req_ready) begin
            // hold the transaction until taken
         end else if (drain_hold || gap_left > 0 || angle_queue.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0 && !drain_hold) gap_left--;
         end else begin
            req_valid <= 1'b1;
            req_angle <= angle_queue.pop_front();
            burst_left--;
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
            end
         end
      end
   end

   // receiver: stall pattern switches between streaming, coin toss and choked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_mode = RX_STREAM;
         mode_left = 100;
      end else begin
         if (mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(32, 400);
         end else begin
            mode_left--;
         end
         case (rx_mode)
            RX_STREAM: rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= $urandom_range(0, 1);
            default:   rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // monitor: predict on request acceptance, check on result acceptance
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            pending_sincos.push_back(predict_sincos(req_angle, count_setting));
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (pending_sincos.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result: cosine %h sine %h",
                        $time, rsp_cosine, rsp_sine);
            end else begin
               want = pending_sincos.pop_front();
               if (rsp_cosine !== want.cosine) begin
                  error_count++;
                  $display("%0t: cosine mismatch, angle %h count %0d: expected %h, actual %h",
                           $time, want.angle, want.count, want.cosine, rsp_cosine);
               end
               if (rsp_sine !== want.sine) begin
                  error_count++;
                  $display("%0t: sine mismatch, angle %h count %0d: expected %h, actual %h",
                           $time, want.angle, want.count, want.sine, rsp_sine);
               end
            end
         end
      end
   end

   // watchdog on cycles with no transaction anywhere
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
                   || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed angles at the reset count: extremes, wrap and fold edges
      push_angle(32'sd0);
      push_angle(32'sd1);
      push_angle(-32'sd1);
      push_angle(32'sh7FFF_FFFF);
      push_angle(32'sh8000_0000);
      push_angle(CODE_PI);
      push_angle(CODE_PI - 1);
      push_angle(-CODE_PI);
      push_angle(-CODE_PI + 1);
      push_angle(CODE_HALF_PI);
      push_angle(CODE_HALF_PI - 1);
      push_angle(-CODE_HALF_PI);
      push_angle(-CODE_HALF_PI + 1);
      push_angle(32'sd268435456);
      push_angle(-32'sd268435456);
      push_angle(32'sd134217728);
      push_angle(32'sh5555_5555);
      push_angle(32'shAAAA_AAAA);
      push_angle(2 * CODE_PI);
      push_angle(-2 * CODE_PI);
      wait_drained();

      // count sweep: zero, one, clamped values, gain table knees, random, then the reset count 32
      run_phase(6'd0);
      run_phase(6'd1);
      run_phase(6'd63);
      run_phase(6'd33);
      run_phase(6'd2);
      run_phase(6'd11);
      run_phase(6'd16);
      run_phase(6'd17);
      run_phase($urandom_range(0, 63));
      run_phase($urandom_range(0, 63));
      run_phase(6'd32);

      repeat (SETTLE) @(posedge clock);
      if (pending_sincos.size() != 0) begin
         error_count++;
         $display("%0t: %0d results never arrived", $time, pending_sincos.size());
      end
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[files.f]
sv/csc_pkg.sv
sv/csc_datapath.sv
sv/cordic_sine_cosine_top.sv
bench/tb_top.sv
